>>> design/rgbct_pkg.sv
// shared constants, types and helpers of the rgb color temperature estimator
package rgbct_pkg;

	// fractional bits of the chromaticity ratio, 16..30
	localparam int FRAC_BITS = 20;

	localparam int IN_W   = 16;
	localparam int KEL_W  = 14;
	localparam int XYZ_W  = 32;                  // signed X and Y
	localparam int SUM_W  = 32;                  // unsigned X+Y+Z
	localparam int K_W    = FRAC_BITS;           // both chromaticity constants are below one
	localparam int NUM_W  = FRAC_BITS + 34;      // signed numerator and denominator
	localparam int MAG_W  = FRAC_BITS + 33;      // their magnitudes
	localparam int REM_W  = MAG_W + 20;          // divider remainder
	localparam int QB     = 20;                  // quotient bits below the saturation bit
	localparam int N_W    = 22;                  // signed n in q.16, saturated to +-16
	localparam int A1_W   = 31;
	localparam int P2_W   = A1_W + N_W;
	localparam int A2_W   = 35;
	localparam int P3_W   = A2_W + N_W;
	localparam int A3_W   = 40;
	localparam int T_W    = A3_W - 16;

	localparam longint K332  = ((64'd3320 << FRAC_BITS) + 64'd5000) / 64'd10000;
	localparam longint K1858 = ((64'd1858 << FRAC_BITS) + 64'd5000) / 64'd10000;

	localparam longint C3 = 64'sd449;
	localparam longint C2 = 64'sd3525 * 64'sd65536;
	localparam longint C1 = 64'sd447171789;
	localparam longint C0 = 64'sd361780347;

	localparam logic [KEL_W-1:0] KMIN  = KEL_W'(1800);
	localparam logic [KEL_W-1:0] KMAX  = KEL_W'(12000);
	localparam logic [KEL_W-1:0] KZERO = KEL_W'(0);

	// pipeline stage count
	localparam int NST = 31;

	typedef struct packed {
		logic             forced;
		logic [KEL_W-1:0] fval;
	} rgbct_ctl_t;

	// divide by 2^16, truncating toward zero
	function automatic logic signed [63:0] trunc16(input logic signed [63:0] p);
		logic signed [63:0] b;
		b = (p < 0) ? 64'sd65535 : 64'sd0;
		return (p + b) >>> 16;
	endfunction

endpackage

>>> design/rgb_color_temperature_estimator.sv
// top level: pipelined mccamy color temperature estimator from rgb counts
//
// Takes one red, green, blue beat and returns one correlated color temperature in
// kelvin (0 when green is zero, else 1800..12000). The sample is mapped to XYZ by a
// fixed q2.14 matrix, McCamy's ratio n = (x-0.3320)/(0.1858-y) is formed by a
// pipelined restoring divider (one quotient bit per stage, saturated to +-16), and
// the cubic is evaluated by Horner's rule with a register after every multiply.
// The pipeline is 31 stages deep, and a new beat is taken every cycle unless the
// whole pipeline is full and stalled by the output side. Each stage has its own
// valid bit and holds only when the stage ahead is full and stalled, so bubbles
// close up and the input side keeps taking beats while a result waits.
module rgb_color_temperature_estimator (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [rgbct_pkg::IN_W-1:0]    red,
	input  logic [rgbct_pkg::IN_W-1:0]    green,
	input  logic [rgbct_pkg::IN_W-1:0]    blue,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [rgbct_pkg::KEL_W-1:0]   kelvin
);

	localparam int NST   = rgbct_pkg::NST;
	localparam int F     = rgbct_pkg::FRAC_BITS;
	localparam int NUM_W = rgbct_pkg::NUM_W;
	localparam int MAG_W = rgbct_pkg::MAG_W;
	localparam int REM_W = rgbct_pkg::REM_W;
	localparam int QB    = rgbct_pkg::QB;
	localparam int N_W   = rgbct_pkg::N_W;
	localparam int KW    = rgbct_pkg::KEL_W;

	// valid bit and load enable per stage
	logic v   [1:NST];
	logic en  [1:NST+1];

	assign en[NST+1] = out_ready;
	for (genvar i = 1; i <= NST; i++) begin : g_en
		assign en[i] = !v[i] || en[i+1];
	end
	assign in_ready  = en[1];
	assign out_valid = v[NST];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 1; i <= NST; i++) v[i] <= 1'b0;
		end else begin
			if (en[1]) v[1] <= in_valid;
			for (int i = 2; i <= NST; i++) begin
				if (en[i]) v[i] <= v[i-1];
			end
		end
	end

	// stage 1: color matrix
	logic signed [33:0] rr, gg, bb, xw, yw;
	logic        [33:0] sw;
	logic signed [rgbct_pkg::XYZ_W-1:0] x_s1, y_s1;
	logic        [rgbct_pkg::SUM_W-1:0] s_s1;
	logic                               gz_s1;

	always_comb begin
		rr = $signed({18'd0, red});
		gg = $signed({18'd0, green});
		bb = $signed({18'd0, blue});
		xw = 34'sd18465 * rr - 34'sd8356 * gg - 34'sd5226 * bb;
		yw = 34'sd6767 * rr + 34'sd9814 * gg - 34'sd934 * bb;
		// column sums of the matrix, so this is X+Y+Z and never negative
		sw = 34'(34'd26166 * {18'd0, red} + 34'd1163 * {18'd0, green}
			+ 34'd14418 * {18'd0, blue});
	end

	always_ff @(posedge clk) begin
		if (en[1]) begin
			x_s1  <= xw[31:0];
			y_s1  <= yw[31:0];
			s_s1  <= sw[31:0];
			gz_s1 <= (green == '0);
		end
	end

	// stage 2: scaled numerator and denominator
	logic [F+31:0] k332s, k1858s;
	logic signed [NUM_W-1:0] num_s2, den_s2;
	logic gz_s2;

	always_comb begin
		k332s  = rgbct_pkg::K332[F-1:0] * s_s1;
		k1858s = rgbct_pkg::K1858[F-1:0] * s_s1;
	end

	always_ff @(posedge clk) begin
		if (en[2]) begin
			num_s2 <= $signed({{2{x_s1[31]}}, x_s1, {F{1'b0}}}) - $signed({2'b00, k332s});
			den_s2 <= $signed({2'b00, k1858s}) - $signed({{2{y_s1[31]}}, y_s1, {F{1'b0}}});
			gz_s2  <= gz_s1;
		end
	end

	// stage 3: magnitudes, sign and the special cases
	logic [NUM_W-1:0] an_w, ad_w;
	logic [MAG_W-1:0] an_s3, ad_s3;
	logic             neg_s3;
	rgbct_pkg::rgbct_ctl_t ctl [3:NST];
	rgbct_pkg::rgbct_ctl_t ctl_new;

	always_comb begin
		an_w = num_s2[NUM_W-1] ? NUM_W'(-num_s2) : NUM_W'(num_s2);
		ad_w = den_s2[NUM_W-1] ? NUM_W'(-den_s2) : NUM_W'(den_s2);
		// green zero wins over a zero denominator
		priority if (gz_s2) begin
			ctl_new.forced = 1'b1;
			ctl_new.fval   = rgbct_pkg::KZERO;
		end else if (den_s2 == '0) begin
			ctl_new.forced = 1'b1;
			ctl_new.fval   = rgbct_pkg::KMAX;
		end else begin
			ctl_new.forced = 1'b0;
			ctl_new.fval   = rgbct_pkg::KZERO;
		end
	end

	always_ff @(posedge clk) begin
		if (en[3]) begin
			an_s3  <= an_w[MAG_W-1:0];
			ad_s3  <= ad_w[MAG_W-1:0];
			neg_s3 <= num_s2[NUM_W-1] != den_s2[NUM_W-1];
			ctl[3] <= ctl_new;
		end
		for (int i = 4; i <= NST; i++) begin
			if (en[i]) ctl[i] <= ctl[i-1];
		end
	end

	// stage 4: divider setup; stages 5..24: one quotient bit each
	logic [REM_W-1:0] drem [0:QB];
	logic [MAG_W-1:0] dad  [0:QB];
	logic [QB-1:0]    dq   [0:QB];
	logic             dsat [0:QB];
	logic             dneg [0:QB];

	always_ff @(posedge clk) begin
		if (en[4]) begin
			drem[0] <= REM_W'({an_s3, 16'd0});
			dad[0]  <= ad_s3;
			dq[0]   <= '0;
			// integer part of n at least 16
			dsat[0] <= REM_W'(an_s3) >= (REM_W'(ad_s3) << 4);
			dneg[0] <= neg_s3;
		end
	end

	for (genvar j = 0; j < QB; j++) begin : g_div
		localparam int K = QB - 1 - j;
		logic [REM_W-1:0] trial;
		logic             take;
		assign trial = REM_W'(dad[j]) << K;
		assign take  = !dsat[j] && (drem[j] >= trial);
		always_ff @(posedge clk) begin
			if (en[5+j]) begin
				drem[j+1] <= take ? drem[j] - trial : drem[j];
				dq[j+1]   <= dq[j] | (take ? (QB'(1) << K) : '0);
				dad[j+1]  <= dad[j];
				dsat[j+1] <= dsat[j];
				dneg[j+1] <= dneg[j];
			end
		end
	end

	// stage 25: signed n in q.16
	logic [N_W-1:0]        qmag;
	logic signed [N_W-1:0] n16_s25, n16_s26, n16_s27, n16_s28;

	assign qmag = dsat[QB] ? (N_W'(1) << QB) : N_W'(dq[QB]);

	always_ff @(posedge clk) begin
		if (en[25]) n16_s25 <= dneg[QB] ? -$signed(qmag) : $signed(qmag);
		if (en[26]) n16_s26 <= n16_s25;
		if (en[27]) n16_s27 <= n16_s26;
		if (en[28]) n16_s28 <= n16_s27;
	end

	// stages 26..30: horner, a register after every multiply
	logic signed [rgbct_pkg::A1_W-1:0] acc1_s26;
	logic signed [rgbct_pkg::P2_W-1:0] p2_s27;
	logic signed [rgbct_pkg::A2_W-1:0] acc2_s28;
	logic signed [rgbct_pkg::P3_W-1:0] p3_s29;
	logic signed [rgbct_pkg::A3_W-1:0] acc3_s30;
	logic signed [63:0] a1w, a2w, a3w;

	always_comb begin
		// the cubic term's rescale is exact, so it reduces to 449 n
		a1w = rgbct_pkg::C3 * 64'(n16_s25) + rgbct_pkg::C2;
		a2w = rgbct_pkg::trunc16(64'(p2_s27)) + rgbct_pkg::C1;
		a3w = rgbct_pkg::trunc16(64'(p3_s29)) + rgbct_pkg::C0;
	end

	always_ff @(posedge clk) begin
		if (en[26]) acc1_s26 <= a1w[rgbct_pkg::A1_W-1:0];
		if (en[27]) p2_s27   <= acc1_s26 * n16_s26;
		if (en[28]) acc2_s28 <= a2w[rgbct_pkg::A2_W-1:0];
		if (en[29]) p3_s29   <= acc2_s28 * n16_s28;
		if (en[30]) acc3_s30 <= a3w[rgbct_pkg::A3_W-1:0];
	end

	// stage 31: integer part, clamp, special cases
	logic signed [rgbct_pkg::T_W-1:0] tint;
	logic [KW-1:0] kel_s31, kel_w;

	always_comb begin
		tint = acc3_s30[rgbct_pkg::A3_W-1:16];
		priority if (ctl[30].forced) begin
			kel_w = ctl[30].fval;
		end else if (tint < $signed({1'b0, rgbct_pkg::KMIN})) begin
			kel_w = rgbct_pkg::KMIN;
		end else if (tint > $signed({1'b0, rgbct_pkg::KMAX})) begin
			kel_w = rgbct_pkg::KMAX;
		end else begin
			kel_w = tint[KW-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (en[31]) kel_s31 <= kel_w;
	end

	// ctl[31] is the output copy of the special case flags, kept for symmetry of the shift
	assign kelvin = (ctl[31].forced) ? ctl[31].fval : kel_s31;

endmodule
